/* sv/dpsm_pkg.sv */
// ----------------------------------------------------------------------------
// dpsm_pkg: shared types and constants of the demand-paged sparse memory
// Request, response and command words, status and command codes, and the
// address split of the two-level page table.
// ----------------------------------------------------------------------------
package dpsm_pkg;

    localparam int ADDR_W   = 32;
    localparam int DATA_W   = 32;
    localparam int REQ_W    = 3;

    // address split: level-one index, level-two index, word in frame
    localparam int IDX_W    = 10;
    localparam int L1_LSB   = 22;
    localparam int L2_LSB   = 12;
    localparam int WORD_LSB = 2;

    localparam int L1_ENTRIES   = 1 << IDX_W;
    localparam int PAGE_ENTRIES = 1 << IDX_W;
    localparam int FRAME_WORDS  = 1 << IDX_W;

    localparam int DEF_TABLE_POOL = 16;
    localparam int DEF_FRAME_POOL = 64;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [REQ_W-1:0] REQ_RD_BYTE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RD_WORD = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WR_BYTE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WR_HALF = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WR_WORD = 3'd4;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_TABLE   = 2'd1,
        ST_NO_FRAME   = 2'd2,
        ST_MISALIGNED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_RD_BYTE,
        CMD_RD_WORD,
        CMD_WR_BYTE,
        CMD_WR_HALF,
        CMD_WR_WORD,
        CMD_DONE
    } cmd_op_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] mem_address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        status_t           status;
    } rsp_t;

    typedef struct packed {
        cmd_op_t           op;
        status_t           status;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef struct packed {
        logic pop;
        logic init;
    } back_ctl_t;

endpackage

/* sv/dpsm_ram.sv */
// ----------------------------------------------------------------------------
// dpsm_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dpsm_ram #(
    parameter int WIDTH = dpsm_pkg::DATA_W,
    parameter int DEPTH = dpsm_pkg::FRAME_WORDS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/dpsm_front.sv */
// ----------------------------------------------------------------------------
// dpsm_front: request intake and classification
// Decodes each request word into a command, settles alignment and unknown
// codes, and holds commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module dpsm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  dpsm_pkg::req_t      req,
    input  logic                req_valid,
    output logic                req_stall,
    input  dpsm_pkg::back_ctl_t ctl,
    output dpsm_pkg::q_head_t   head
);

    dpsm_pkg::cmd_t                    cmd_in;
    dpsm_pkg::cmd_t                    q_reg [dpsm_pkg::QUEUE_DEPTH];
    logic [dpsm_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [dpsm_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [dpsm_pkg::QCNT_W-1:0]       count_reg;
    logic [dpsm_pkg::QCNT_W-1:0]       count_next;
    logic                              push;

    always_comb
    begin
        cmd_in.addr   = req.mem_address;
        cmd_in.data   = req.write_data;
        cmd_in.status = dpsm_pkg::ST_OK;
        cmd_in.op     = dpsm_pkg::CMD_DONE;
        unique case (req.req_type)
            dpsm_pkg::REQ_RD_BYTE:
            begin
                cmd_in.op = dpsm_pkg::CMD_RD_BYTE;
            end
            dpsm_pkg::REQ_RD_WORD:
            begin
                if (req.mem_address[1:0] != 2'b00)
                begin
                    cmd_in.status = dpsm_pkg::ST_MISALIGNED;
                end
                else
                begin
                    cmd_in.op = dpsm_pkg::CMD_RD_WORD;
                end
            end
            dpsm_pkg::REQ_WR_BYTE:
            begin
                cmd_in.op = dpsm_pkg::CMD_WR_BYTE;
            end
            dpsm_pkg::REQ_WR_HALF:
            begin
                if (req.mem_address[0])
                begin
                    cmd_in.status = dpsm_pkg::ST_MISALIGNED;
                end
                else
                begin
                    cmd_in.op = dpsm_pkg::CMD_WR_HALF;
                end
            end
            dpsm_pkg::REQ_WR_WORD:
            begin
                if (req.mem_address[1:0] != 2'b00)
                begin
                    cmd_in.status = dpsm_pkg::ST_MISALIGNED;
                end
                else
                begin
                    cmd_in.op = dpsm_pkg::CMD_WR_WORD;
                end
            end
            default:
            begin
                // unknown code: answer ok with zero data, touch nothing
                cmd_in.op = dpsm_pkg::CMD_DONE;
            end
        endcase
    end

    // hold off intake while the queue is full or the back end clears its tables
    assign req_stall = (count_reg == dpsm_pkg::QCNT_W'(dpsm_pkg::QUEUE_DEPTH)) || ctl.init;
    assign push      = req_valid && !req_stall;

    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !ctl.pop)
        begin
            count_next = count_reg + dpsm_pkg::QCNT_W'(1);
        end
        else if (!push && ctl.pop)
        begin
            count_next = count_reg - dpsm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + dpsm_pkg::QPTR_W'(1);
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + dpsm_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dpsm_pkg::QCNT_W'(dpsm_pkg::QUEUE_DEPTH))
        else $error("command queue over its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> head.valid)
        else $error("pop from an empty command queue");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == dpsm_pkg::QCNT_W'(dpsm_pkg::QUEUE_DEPTH)) |-> req_stall)
        else $error("intake open while command queue is full");
`endif

endmodule

/* sv/dpsm_back.sv */
// ----------------------------------------------------------------------------
// dpsm_back: page walk, allocation and frame access
// Walks level one, level two and the frame store one registered read at a
// time, allocates and clears tables and frames on writes, drives the response.
// ----------------------------------------------------------------------------
module dpsm_back #(
    parameter int TABLE_POOL = dpsm_pkg::DEF_TABLE_POOL,
    parameter int FRAME_POOL = dpsm_pkg::DEF_FRAME_POOL
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dpsm_pkg::q_head_t   head,
    output dpsm_pkg::back_ctl_t ctl,
    output dpsm_pkg::rsp_t      rsp,
    output logic                rsp_valid,
    input  logic                rsp_stall
);

    localparam int TW       = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int FW       = (FRAME_POOL > 1) ? $clog2(FRAME_POOL) : 1;
    localparam int TU_W     = $clog2(TABLE_POOL + 1);
    localparam int FU_W     = $clog2(FRAME_POOL + 1);
    localparam int L1_W     = TW + 1;
    localparam int L2_W     = FW + 1;
    localparam int L1_AW    = dpsm_pkg::IDX_W;
    localparam int L2_DEPTH = TABLE_POOL * dpsm_pkg::PAGE_ENTRIES;
    localparam int L2_AW    = $clog2(L2_DEPTH);
    localparam int FR_DEPTH = FRAME_POOL * dpsm_pkg::FRAME_WORDS;
    localparam int FR_AW    = $clog2(FR_DEPTH);
    localparam int IW       = dpsm_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_L1,
        S_L2_CLR,
        S_L2_RD,
        S_L2,
        S_FR_CLR,
        S_FR_RD,
        S_FR
    } state_t;

    state_t                   state_reg, state_next;
    dpsm_pkg::cmd_t           cmd_reg, cmd_next;
    logic [TW-1:0]            tbl_reg, tbl_next;
    logic [FW-1:0]            frm_reg, frm_next;
    logic [IW-1:0]            cnt_reg, cnt_next;
    logic [TU_W-1:0]          tables_used_reg, tables_used_next;
    logic [FU_W-1:0]          frames_used_reg, frames_used_next;
    dpsm_pkg::rsp_t           rsp_reg, rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic                     l1_we;
    logic [L1_AW-1:0]         l1_waddr, l1_raddr;
    logic [L1_W-1:0]          l1_wdata, l1_rdata;
    logic                     l2_we;
    logic [L2_AW-1:0]         l2_waddr, l2_raddr;
    logic [L2_W-1:0]          l2_wdata, l2_rdata;
    logic                     fr_we;
    logic [FR_AW-1:0]         fr_waddr, fr_raddr;
    logic [dpsm_pkg::DATA_W-1:0] fr_wdata, fr_rdata;

    logic                     out_free;
    logic                     is_write;
    logic [IW-1:0]            cur_i1, cur_i2, cur_widx;
    logic [1:0]               lane;
    logic [7:0]               byte_sel;

    assign cur_i1   = cmd_reg.addr[dpsm_pkg::L1_LSB +: IW];
    assign cur_i2   = cmd_reg.addr[dpsm_pkg::L2_LSB +: IW];
    assign cur_widx = cmd_reg.addr[dpsm_pkg::WORD_LSB +: IW];
    assign lane     = cmd_reg.addr[1:0];
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign is_write = (cmd_reg.op == dpsm_pkg::CMD_WR_BYTE)
                   || (cmd_reg.op == dpsm_pkg::CMD_WR_HALF)
                   || (cmd_reg.op == dpsm_pkg::CMD_WR_WORD);

    // big-endian byte pick from the frame word
    always_comb
    begin
        unique case (lane)
            2'd0:    byte_sel = fr_rdata[31:24];
            2'd1:    byte_sel = fr_rdata[23:16];
            2'd2:    byte_sel = fr_rdata[15:8];
            default: byte_sel = fr_rdata[7:0];
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        tbl_next         = tbl_reg;
        frm_next         = frm_reg;
        cnt_next         = cnt_reg;
        tables_used_next = tables_used_reg;
        frames_used_next = frames_used_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;

        l1_we    = 1'b0;
        l1_waddr = cnt_reg;
        l1_wdata = '0;
        l1_raddr = head.cmd.addr[dpsm_pkg::L1_LSB +: IW];
        l2_we    = 1'b0;
        l2_waddr = L2_AW'({tbl_reg, cnt_reg});
        l2_wdata = '0;
        l2_raddr = L2_AW'({tbl_reg, cur_i2});
        fr_we    = 1'b0;
        fr_waddr = FR_AW'({frm_reg, cnt_reg});
        fr_wdata = '0;
        fr_raddr = FR_AW'({frm_reg, cur_widx});

        ctl.pop  = 1'b0;
        ctl.init = (state_reg == S_INIT);

        unique case (state_reg)
            S_INIT:
            begin
                // sweep level one to invalid after reset
                l1_we    = 1'b1;
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    ctl.pop  = 1'b1;
                    cmd_next = head.cmd;
                    if (head.cmd.op == dpsm_pkg::CMD_DONE)
                    begin
                        rsp_next.read_data = '0;
                        rsp_next.status    = head.cmd.status;
                        rsp_valid_next     = 1'b1;
                    end
                    else
                    begin
                        state_next = S_L1;
                    end
                end
            end
            S_L1:
            begin
                if (l1_rdata[TW])
                begin
                    tbl_next   = l1_rdata[TW-1:0];
                    l2_raddr   = L2_AW'({l1_rdata[TW-1:0], cur_i2});
                    state_next = S_L2;
                end
                else if (!is_write)
                begin
                    rsp_next.read_data = '0;
                    rsp_next.status    = dpsm_pkg::ST_OK;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
                else if (tables_used_reg == TU_W'(TABLE_POOL))
                begin
                    rsp_next.read_data = '0;
                    rsp_next.status    = dpsm_pkg::ST_NO_TABLE;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    // take the next table and clear it
                    l1_we            = 1'b1;
                    l1_waddr         = cur_i1;
                    l1_wdata         = {1'b1, TW'(tables_used_reg)};
                    tbl_next         = TW'(tables_used_reg);
                    tables_used_next = tables_used_reg + TU_W'(1);
                    cnt_next         = '0;
                    state_next       = S_L2_CLR;
                end
            end
            S_L2_CLR:
            begin
                l2_we    = 1'b1;
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == '1)
                begin
                    state_next = S_L2_RD;
                end
            end
            S_L2_RD:
            begin
                state_next = S_L2;
            end
            S_L2:
            begin
                if (l2_rdata[FW])
                begin
                    frm_next   = l2_rdata[FW-1:0];
                    fr_raddr   = FR_AW'({l2_rdata[FW-1:0], cur_widx});
                    state_next = S_FR;
                end
                else if (!is_write)
                begin
                    rsp_next.read_data = '0;
                    rsp_next.status    = dpsm_pkg::ST_OK;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
                else if (frames_used_reg == FU_W'(FRAME_POOL))
                begin
                    // a table taken by this write stays taken
                    rsp_next.read_data = '0;
                    rsp_next.status    = dpsm_pkg::ST_NO_FRAME;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    // take the next frame and clear it
                    l2_we            = 1'b1;
                    l2_waddr         = L2_AW'({tbl_reg, cur_i2});
                    l2_wdata         = {1'b1, FW'(frames_used_reg)};
                    frm_next         = FW'(frames_used_reg);
                    frames_used_next = frames_used_reg + FU_W'(1);
                    cnt_next         = '0;
                    state_next       = S_FR_CLR;
                end
            end
            S_FR_CLR:
            begin
                fr_we    = 1'b1;
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == '1)
                begin
                    state_next = S_FR_RD;
                end
            end
            S_FR_RD:
            begin
                state_next = S_FR;
            end
            S_FR:
            begin
                rsp_next.read_data = '0;
                rsp_next.status    = dpsm_pkg::ST_OK;
                fr_waddr           = FR_AW'({frm_reg, cur_widx});
                fr_wdata           = fr_rdata;
                unique case (cmd_reg.op)
                    dpsm_pkg::CMD_RD_BYTE:
                    begin
                        rsp_next.read_data = {24'd0, byte_sel};
                    end
                    dpsm_pkg::CMD_RD_WORD:
                    begin
                        rsp_next.read_data = fr_rdata;
                    end
                    dpsm_pkg::CMD_WR_BYTE:
                    begin
                        fr_we = 1'b1;
                        unique case (lane)
                            2'd0:    fr_wdata[31:24] = cmd_reg.data[7:0];
                            2'd1:    fr_wdata[23:16] = cmd_reg.data[7:0];
                            2'd2:    fr_wdata[15:8]  = cmd_reg.data[7:0];
                            default: fr_wdata[7:0]   = cmd_reg.data[7:0];
                        endcase
                    end
                    dpsm_pkg::CMD_WR_HALF:
                    begin
                        fr_we = 1'b1;
                        if (lane[1])
                        begin
                            fr_wdata[15:0] = cmd_reg.data[15:0];
                        end
                        else
                        begin
                            fr_wdata[31:16] = cmd_reg.data[15:0];
                        end
                    end
                    dpsm_pkg::CMD_WR_WORD:
                    begin
                        fr_we    = 1'b1;
                        fr_wdata = cmd_reg.data;
                    end
                    default:
                    begin
                        fr_we = 1'b0;
                    end
                endcase
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            cmd_reg         <= '0;
            tbl_reg         <= '0;
            frm_reg         <= '0;
            cnt_reg         <= '0;
            tables_used_reg <= '0;
            frames_used_reg <= '0;
            rsp_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            tbl_reg         <= tbl_next;
            frm_reg         <= frm_next;
            cnt_reg         <= cnt_next;
            tables_used_reg <= tables_used_next;
            frames_used_reg <= frames_used_next;
            rsp_reg         <= rsp_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    dpsm_ram #(
        .WIDTH (L1_W),
        .DEPTH (dpsm_pkg::L1_ENTRIES)
    ) u_l1_ram (
        .clk   (clk),
        .we    (l1_we),
        .waddr (l1_waddr),
        .wdata (l1_wdata),
        .raddr (l1_raddr),
        .rdata (l1_rdata)
    );

    dpsm_ram #(
        .WIDTH (L2_W),
        .DEPTH (L2_DEPTH)
    ) u_l2_ram (
        .clk   (clk),
        .we    (l2_we),
        .waddr (l2_waddr),
        .wdata (l2_wdata),
        .raddr (l2_raddr),
        .rdata (l2_rdata)
    );

    dpsm_ram #(
        .WIDTH (dpsm_pkg::DATA_W),
        .DEPTH (FR_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

`ifndef SYNTHESIS
    a_table_pool: assert property (@(posedge clk) disable iff (!rst_n)
        tables_used_reg <= TU_W'(TABLE_POOL))
        else $error("table pool count past its size");

    a_frame_pool: assert property (@(posedge clk) disable iff (!rst_n)
        frames_used_reg <= FU_W'(FRAME_POOL))
        else $error("frame pool count past its size");

    a_pop_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (out_free && (state_reg == S_IDLE)))
        else $error("command taken while response word still pending");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != dpsm_pkg::ST_OK)) |-> (rsp_reg.read_data == '0))
        else $error("error response carries data");
`endif

endmodule

/* sv/demand_paged_sparse_memory_core.sv */
// ----------------------------------------------------------------------------
// demand_paged_sparse_memory_core: sparse 32-bit big-endian memory
// Two-level page table with tables and frames allocated on first write.
// ----------------------------------------------------------------------------
// After reset the core clears its level-one table and holds req_stall high
// meanwhile. A request whose page is mapped takes the word from the queue,
// then makes one registered read each of level one, level two and the frame
// store; the walk ends after the level-two read at a missing level-two entry
// or an empty frame pool, and after the level-one read at a missing level-one
// entry or an empty table pool; a misaligned or unknown request is answered
// as it is taken from the queue. A write that allocates a level-two table
// first clears it, and one that allocates a frame first clears the frame.
// A two-word queue sits between intake and the page walk and keeps taking
// words while a result waits on rsp_stall; the walk starts the next word
// only once the response register is free.
module demand_paged_sparse_memory_core #(
    parameter int TABLE_POOL = dpsm_pkg::DEF_TABLE_POOL,
    parameter int FRAME_POOL = dpsm_pkg::DEF_FRAME_POOL
) (
    input  logic           clk,
    input  logic           rst_n,
    input  dpsm_pkg::req_t req,
    input  logic           req_valid,
    output logic           req_stall,
    output dpsm_pkg::rsp_t rsp,
    output logic           rsp_valid,
    input  logic           rsp_stall
);

    dpsm_pkg::q_head_t   head;
    dpsm_pkg::back_ctl_t ctl;

    dpsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .ctl       (ctl),
        .head      (head)
    );

    dpsm_back #(
        .TABLE_POOL (TABLE_POOL),
        .FRAME_POOL (FRAME_POOL)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .ctl       (ctl),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule
